// ----- rtl/five_bit_string_packer_core_assert.svh -----
// Assertion macros for the five-bit string packer, compiled out under SYNTHESIS.
`ifndef FIVE_BIT_STRING_PACKER_CORE_ASSERT_SVH
`define FIVE_BIT_STRING_PACKER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define FBSP_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define FBSP_ASSERT(lbl, prop, msg) `FBSP_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)
`else
`define FBSP_ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define FBSP_ASSERT(lbl, prop, msg)
`endif
`endif

// ----- rtl/fbsp_pkg.sv -----
// Shared types, codes and the character map of the five-bit string packer.
`timescale 1ns / 1ps
package fbsp_pkg;

  localparam logic ACTION_BEGIN = 1'b0;
  localparam logic ACTION_CHAR  = 1'b1;

  localparam int FIFO_DEPTH = 2;

  // Index of the last byte a length prefix may take (five bytes).
  localparam logic [2:0] LEN_LAST_IDX = 3'd4;

  localparam logic [4:0] CODE_PIPE  = 5'd10;
  localparam logic [4:0] CODE_COMMA = 5'd11;
  localparam logic [4:0] CODE_ALPHA = 5'd12;

  typedef enum logic [1:0] {
    KIND_LEN,
    KIND_CHAR,
    KIND_BAD
  } kind_e;

  typedef struct packed {
    kind_e kind;
    logic  two_bytes;
  } fbsp_ctrl_t;

  // Map an ASCII byte to {valid, 5-bit code}.
  function automatic logic [5:0] char_code(input logic [7:0] c);
    logic [7:0] d;
    logic [7:0] a;
    d = c - 8'h30;
    a = c - 8'h41;
    if (c >= 8'h30 && c <= 8'h39) begin
      char_code = {1'b1, d[4:0]};
    end else if (c == 8'h7C) begin
      char_code = {1'b1, CODE_PIPE};
    end else if (c == 8'h2C) begin
      char_code = {1'b1, CODE_COMMA};
    end else if (c >= 8'h41 && c <= 8'h54) begin
      char_code = {1'b1, CODE_ALPHA + a[4:0]};
    end else begin
      char_code = 6'd0;
    end
  endfunction

endpackage

// ----- rtl/fbsp_front.sv -----
// Front end: accepts items, packs 5-bit codes and queues output work.
`timescale 1ns / 1ps
module fbsp_front #(
  parameter int LENGTH_BITS = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   action_i,
  input  logic [31:0]            string_length_i,
  input  logic [7:0]             char_byte_i,
  input  logic                   final_char_i,
  input  logic                   fifo_full_i,
  output logic                   push_o,
  output fbsp_pkg::fbsp_ctrl_t   push_ctrl_o,
  output logic [LENGTH_BITS-1:0] push_len_o,
  output logic [15:0]            push_data_o
);
  import fbsp_pkg::*;

  logic [6:0]              pend_q, pend_d;
  logic [2:0]              cnt_q, cnt_d;
  logic                    abort_q, abort_d;
  logic                    accept;
  logic [5:0]              cc;
  logic [11:0]             acc;
  logic [3:0]              cnt5;
  logic [7:0]              rem;
  logic [2:0]              rc;
  logic                    flush;
  logic [LENGTH_BITS+31:0] len_ext;

  assign in_stall_o = fifo_full_i;
  assign accept     = in_valid_i && !fifo_full_i;
  assign len_ext    = {{LENGTH_BITS{1'b0}}, string_length_i};
  assign push_len_o = len_ext[LENGTH_BITS-1:0];

  always_comb begin
    cc    = char_code(char_byte_i);
    acc   = {5'b0, pend_q} | ({7'b0, cc[4:0]} << cnt_q);
    cnt5  = {1'b0, cnt_q} + 4'd5;
    rc    = cnt5[2:0];
    rem   = cnt5[3] ? {4'b0, acc[11:8]} : acc[7:0];
    flush = final_char_i && (rc != 3'd0);

    push_o                = 1'b0;
    push_ctrl_o.kind      = KIND_CHAR;
    push_ctrl_o.two_bytes = 1'b0;
    push_data_o           = cnt5[3] ? {rem, acc[7:0]} : {8'b0, rem};
    pend_d                = pend_q;
    cnt_d                 = cnt_q;
    abort_d               = abort_q;

    if (accept) begin
      if (action_i == ACTION_BEGIN) begin
        // Drop any open string and queue the length prefix.
        push_o           = 1'b1;
        push_ctrl_o.kind = KIND_LEN;
        pend_d           = 7'd0;
        cnt_d            = 3'd0;
        abort_d          = 1'b0;
      end else if (!abort_q) begin
        if (!cc[5]) begin
          push_o           = 1'b1;
          push_ctrl_o.kind = KIND_BAD;
          pend_d           = 7'd0;
          cnt_d            = 3'd0;
          abort_d          = 1'b1;
        end else begin
          push_o                = cnt5[3] || flush;
          push_ctrl_o.two_bytes = cnt5[3] && flush;
          pend_d                = final_char_i ? 7'd0 : rem[6:0];
          cnt_d                 = final_char_i ? 3'd0 : rc;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q  <= 7'd0;
      cnt_q   <= 3'd0;
      abort_q <= 1'b0;
    end else begin
      pend_q  <= pend_d;
      cnt_q   <= cnt_d;
      abort_q <= abort_d;
    end
  end

endmodule

// ----- rtl/fbsp_fifo.sv -----
// Short work queue between the front and back ends.
`timescale 1ns / 1ps
module fbsp_fifo #(
  parameter int LENGTH_BITS = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  fbsp_pkg::fbsp_ctrl_t   push_ctrl_i,
  input  logic [LENGTH_BITS-1:0] push_len_i,
  input  logic [15:0]            push_data_i,
  input  logic                   pop_i,
  output logic                   full_o,
  output logic                   empty_o,
  output fbsp_pkg::fbsp_ctrl_t   head_ctrl_o,
  output logic [LENGTH_BITS-1:0] head_len_o,
  output logic [15:0]            head_data_o
);
  import fbsp_pkg::*;

  localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);

  fbsp_ctrl_t             ctrl_q [FIFO_DEPTH];
  logic [LENGTH_BITS-1:0] len_q  [FIFO_DEPTH];
  logic [15:0]            data_q [FIFO_DEPTH];
  logic [PTR_W-1:0]       wr_q, rd_q;
  logic [CNT_W-1:0]       cnt_q;

  assign full_o      = (cnt_q == CNT_FULL);
  assign empty_o     = (cnt_q == '0);
  assign head_ctrl_o = ctrl_q[rd_q];
  assign head_len_o  = len_q[rd_q];
  assign head_data_o = data_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ctrl_q[wr_q] <= push_ctrl_i;
      len_q[wr_q]  <= push_len_i;
      data_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PTR_LAST) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PTR_LAST) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/fbsp_back.sv -----
// Back end: expands queued work into result bytes, one per cycle while the output is not stalled.
`timescale 1ns / 1ps
module fbsp_back #(
  parameter int LENGTH_BITS = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   empty_i,
  input  fbsp_pkg::fbsp_ctrl_t   head_ctrl_i,
  input  logic [LENGTH_BITS-1:0] head_len_i,
  input  logic [15:0]            head_data_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [7:0]             out_byte_o,
  output logic                   bad_char_o,
  output logic                   run_end_o
);
  import fbsp_pkg::*;

  localparam int W = LENGTH_BITS + 7;

  fbsp_ctrl_t   cur_q;
  logic [W-1:0] work_q;
  logic [15:0]  data_q;
  logic [2:0]   idx_q;
  logic         busy_q;
  logic         ov_q;
  logic [7:0]   byte_q;
  logic         bad_q;
  logic         end_q;
  logic [7:0]   res_byte;
  logic         res_bad;
  logic         res_last;
  logic         more;
  logic         adv;
  logic         emit;

  assign more = |work_q[W-1:7];

  always_comb begin
    res_bad = 1'b0;
    case (cur_q.kind)
      KIND_LEN: begin
        res_byte = {more, work_q[6:0]};
        res_last = !more || (idx_q == LEN_LAST_IDX);
      end
      KIND_CHAR: begin
        res_byte = idx_q[0] ? data_q[15:8] : data_q[7:0];
        res_last = idx_q[0] || !cur_q.two_bytes;
      end
      KIND_BAD: begin
        res_byte = 8'd0;
        res_bad  = 1'b1;
        res_last = 1'b1;
      end
      default: begin
        res_byte = 8'd0;
        res_last = 1'b1;
      end
    endcase
  end

  assign adv   = !ov_q || !out_stall_i;
  assign emit  = busy_q && adv;
  assign pop_o = !empty_i && (!busy_q || (emit && res_last));

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q  <= head_ctrl_i;
      work_q <= {7'd0, head_len_i};
      data_q <= head_data_i;
    end else if (emit) begin
      work_q <= work_q >> 7;
    end
    if (emit) begin
      byte_q <= res_byte;
      bad_q  <= res_bad;
      end_q  <= res_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= 3'd0;
      ov_q   <= 1'b0;
    end else begin
      if (pop_o) begin
        busy_q <= 1'b1;
        idx_q  <= 3'd0;
      end else if (emit) begin
        busy_q <= !res_last;
        idx_q  <= idx_q + 3'd1;
      end
      if (emit) begin
        ov_q <= 1'b1;
      end else if (!out_stall_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = ov_q;
  assign out_byte_o  = byte_q;
  assign bad_char_o  = bad_q;
  assign run_end_o   = end_q;

endmodule

// ----- rtl/five_bit_string_packer_core.sv -----
// Top level of the five-bit string packer: LEB128 length prefix and 5-bit packing.
// The first result of a transaction passes through the queue, the back end's work registers and the output register.
// Throughput: one input transaction per cycle while the queue has room and one result per
// cycle while the output is not stalled; a begin gives 1 to 5 result bytes and a character at most 2.
// Reset (rst_ni low, asynchronous) empties the queue and clears the packing state.
`timescale 1ns / 1ps
`include "five_bit_string_packer_core_assert.svh"
module five_bit_string_packer_core #(
  parameter int LENGTH_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        action_i,
  input  logic [31:0] string_length_i,
  input  logic [7:0]  char_byte_i,
  input  logic        final_char_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        bad_char_o,
  output logic        run_end_o
);
  import fbsp_pkg::*;

  // Queue entries: the control word, the masked length and up to two packed bytes.
  logic                   push;
  fbsp_ctrl_t             push_ctrl;
  logic [LENGTH_BITS-1:0] push_len;
  logic [15:0]            push_data;
  logic                   pop;
  logic                   fifo_full;
  logic                   fifo_empty;
  fbsp_ctrl_t             head_ctrl;
  logic [LENGTH_BITS-1:0] head_len;
  logic [15:0]            head_data;

  // Front: accept a transaction whenever the queue has room, update the packing
  // state at once and queue any bytes it produces.
  fbsp_front #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .action_i,
    .string_length_i,
    .char_byte_i,
    .final_char_i,
    .fifo_full_i (fifo_full),
    .push_o      (push),
    .push_ctrl_o (push_ctrl),
    .push_len_o  (push_len),
    .push_data_o (push_data)
  );

  // Queue: decouple input stalls from output stalls.
  fbsp_fifo #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_fifo (
    .clk_i,
    .rst_ni,
    .push_i      (push),
    .push_ctrl_i (push_ctrl),
    .push_len_i  (push_len),
    .push_data_i (push_data),
    .pop_i       (pop),
    .full_o      (fifo_full),
    .empty_o     (fifo_empty),
    .head_ctrl_o (head_ctrl),
    .head_len_o  (head_len),
    .head_data_o (head_data)
  );

  // Back: advance one byte per cycle into the output register while the output is not stalled;
  // pop the next entry in the same cycle the current one emits its last byte.
  fbsp_back #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_back (
    .clk_i,
    .rst_ni,
    .empty_i     (fifo_empty),
    .head_ctrl_i (head_ctrl),
    .head_len_i  (head_len),
    .head_data_i (head_data),
    .pop_o       (pop),
    .out_valid_o,
    .out_stall_i,
    .out_byte_o,
    .bad_char_o,
    .run_end_o
  );

  // The front never pushes into a full queue, and the back never pops an empty one.
  `FBSP_ASSERT(a_no_overflow, fifo_full |-> !push, "push into full queue")
  `FBSP_ASSERT(a_no_underflow, pop |-> !fifo_empty, "pop from empty queue")
  // An error result is a single zero byte that closes its transaction.
  `FBSP_ASSERT(a_bad_result, out_valid_o && bad_char_o |-> run_end_o && out_byte_o == 8'd0,
               "malformed error result")

endmodule
